FILE: design/jdda_pkg.sv
// jdda_pkg: shared constants, types and the jitter hash fold for the jittered DDA line rasterizer.
// No dependencies; every design file imports it.
package jdda_pkg;

  localparam int X_BITS_DEF = 7;
  localparam int Y_BITS_DEF = 6;

  // Only the low bits of the multiplicative hash matter: bits 1:0 and 17:16, which the fold combines.
  localparam int HASH_BITS = 18;
  localparam int HASH_FOLD = 16;
  localparam logic [31:0] HASH_K = 32'd2654435761;
  localparam logic [HASH_BITS-1:0] HASH_K_LO = HASH_K[HASH_BITS-1:0];
  localparam logic [HASH_BITS-1:0] HASH_STEP2 = {HASH_K_LO[HASH_BITS-2:0], 1'b0};
  localparam logic [HASH_BITS-1:0] SEED_MUL_X = HASH_BITS'(7);
  localparam logic [HASH_BITS-1:0] SEED_MUL_Y = HASH_BITS'(13);

  localparam int QUEUE_DEPTH = 2;

  localparam int OUT_X_BITS  = 9;
  localparam int OUT_Y_BITS  = 8;
  localparam int VIEW_W_BITS = 8;
  localparam int VIEW_H_BITS = 7;
  localparam logic [VIEW_W_BITS-1:0] VIEW_W_RST = 8'd128;
  localparam logic [VIEW_H_BITS-1:0] VIEW_H_RST = 7'd48;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VIEW_WIDTH  = 2'd0,
    CFG_VIEW_HEIGHT = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [VIEW_W_BITS-1:0] width;
    logic [VIEW_H_BITS-1:0] height;
  } view_cfg_t;

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic x_major;
  } line_flags_t;

  // Width of one queued line: x0, y0, |dx|, |dy|, steps, flags, hash seed.
  function automatic int entry_bits(input int xb, input int yb);
    int sw;
    sw = (xb > yb) ? xb : yb;
    return xb + yb + 3 * sw + $bits(line_flags_t) + HASH_BITS;
  endfunction

  // Fold the hash by 16 bits and map the low two bits to -1, 0, +1 (3 clamps to +1).
  function automatic logic signed [1:0] jitter_of(input logic [HASH_BITS-1:0] h);
    logic [1:0] f;
    logic signed [1:0] v;
    f = h[1:0] ^ h[HASH_FOLD+1:HASH_FOLD];
    case (f)
      2'd0:    v = -2'sd1;
      2'd1:    v = 2'sd0;
      default: v = 2'sd1;
    endcase
    return v;
  endfunction

endpackage

FILE: design/jdda_front.sv
// jdda_front: accepts a line, computes deltas, step count, major axis and hash seed.
// Drops zero-length lines. Depends on jdda_pkg.
module jdda_front #(
  parameter int X_BITS = jdda_pkg::X_BITS_DEF,
  parameter int Y_BITS = jdda_pkg::Y_BITS_DEF,
  parameter int EW     = jdda_pkg::entry_bits(jdda_pkg::X_BITS_DEF, jdda_pkg::Y_BITS_DEF)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [X_BITS-1:0] in_start_x,
  input  logic [Y_BITS-1:0] in_start_y,
  input  logic [X_BITS-1:0] in_end_x,
  input  logic [Y_BITS-1:0] in_end_y,
  output logic              push_valid,
  input  logic              push_full,
  output logic [EW-1:0]     push_data
);
  import jdda_pkg::*;

  localparam int SW = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;

  logic                     v_r;
  logic [X_BITS-1:0]        x0_r;
  logic [Y_BITS-1:0]        y0_r;
  logic signed [X_BITS:0]   dx_r, dx_nxt;
  logic signed [Y_BITS:0]   dy_r, dy_nxt;
  logic [HASH_BITS-1:0]     seed_r, seed_nxt;

  logic signed [X_BITS:0]   ndx;
  logic signed [Y_BITS:0]   ndy;
  logic [X_BITS-1:0]        adx;
  logic [Y_BITS-1:0]        ady;
  logic [SW-1:0]            adx_w, ady_w, steps;
  line_flags_t              flags;
  logic [HASH_BITS-1:0]     hseed;
  logic                     zero_len, advance;

  assign dx_nxt   = $signed({1'b0, in_end_x}) - $signed({1'b0, in_start_x});
  assign dy_nxt   = $signed({1'b0, in_end_y}) - $signed({1'b0, in_start_y});
  assign seed_nxt = HASH_BITS'(in_start_x) * SEED_MUL_X + HASH_BITS'(in_start_y) * SEED_MUL_Y;

  assign ndx = -dx_r;
  assign ndy = -dy_r;
  assign adx = dx_r[X_BITS] ? ndx[X_BITS-1:0] : dx_r[X_BITS-1:0];
  assign ady = dy_r[Y_BITS] ? ndy[Y_BITS-1:0] : dy_r[Y_BITS-1:0];
  assign adx_w = SW'(adx);
  assign ady_w = SW'(ady);
  assign steps = (adx_w > ady_w) ? adx_w : ady_w;

  assign flags.x_neg   = dx_r[X_BITS];
  assign flags.y_neg   = dy_r[Y_BITS];
  assign flags.x_major = adx_w > ady_w;

  // Hash of (seed + i) at i = 0; the walker adds multiples of the key from here.
  assign hseed = seed_r * HASH_K_LO;

  assign zero_len   = (steps == '0);
  assign push_valid = v_r && !zero_len;
  assign advance    = !v_r || zero_len || !push_full;
  assign in_stall   = !advance;
  assign push_data  = {x0_r, y0_r, adx_w, ady_w, steps, flags, hseed};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (advance) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      x0_r   <= in_start_x;
      y0_r   <= in_start_y;
      dx_r   <= dx_nxt;
      dy_r   <= dy_nxt;
      seed_r <= seed_nxt;
    end
  end

endmodule

FILE: design/jdda_fifo.sv
// jdda_fifo: short queue of classified lines between front and walker.
// Depends on jdda_pkg for its depth.
module jdda_fifo #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push_valid,
  output logic         push_full,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);
  import jdda_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [W-1:0]    slot_r [DEPTH];
  logic [PW-1:0]   wr_r, rd_r;
  logic [CNTW-1:0] count_r;
  logic            push, pop;

  assign push_full = (count_r == CNTW'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign push      = push_valid && !push_full;
  assign pop       = pop_ready && pop_valid;
  assign pop_data  = slot_r[rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (push) wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + PW'(1);
      if (pop)  rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + PW'(1);
      if (push && !pop) count_r <= count_r + CNTW'(1);
      else if (pop && !push) count_r <= count_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= push_data;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNTW'(DEPTH)) else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNTW'(1)))
    else $error("queue count missed a push");

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !push) |=> (count_r == $past(count_r) - CNTW'(1)))
    else $error("queue count missed a pop");

endmodule

FILE: design/jdda_back.sv
// jdda_back: walks one queued line, two dots per beat, with incremental quotients and hash.
// Depends on jdda_pkg.
module jdda_back #(
  parameter int X_BITS = jdda_pkg::X_BITS_DEF,
  parameter int Y_BITS = jdda_pkg::Y_BITS_DEF,
  parameter int EW     = jdda_pkg::entry_bits(jdda_pkg::X_BITS_DEF, jdda_pkg::Y_BITS_DEF)
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  jdda_pkg::view_cfg_t                    view_cfg,
  input  logic                                   q_valid,
  output logic                                   q_pop,
  input  logic [EW-1:0]                          q_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [jdda_pkg::OUT_X_BITS-1:0] out_first_dot_x,
  output logic signed [jdda_pkg::OUT_Y_BITS-1:0] out_first_dot_y,
  output logic                                   out_first_dot_draw,
  output logic signed [jdda_pkg::OUT_X_BITS-1:0] out_second_dot_x,
  output logic signed [jdda_pkg::OUT_Y_BITS-1:0] out_second_dot_y,
  output logic                                   out_second_dot_draw,
  output logic                                   out_last_pair
);
  import jdda_pkg::*;

  localparam int SW = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int IW = SW + 1;
  localparam int QW = SW + 1;
  localparam int RW = SW + 1;
  localparam int CW = ((SW > 8) ? SW : 8) + 2;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WALK = 2'b10
  } walk_st_t;

  typedef struct packed {
    logic [QW-1:0] q;
    logic [RW-1:0] r;
  } acc_t;

  // One DDA step: quotient and remainder of d*i/s moved to i+1 (d <= s).
  function automatic acc_t dda_step(input acc_t a, input logic [SW-1:0] d,
                                    input logic [SW-1:0] s);
    acc_t n;
    logic [RW-1:0] sum;
    sum = a.r + RW'(d);
    if (sum >= RW'(s)) begin
      n.q = a.q + QW'(1);
      n.r = sum - RW'(s);
    end else begin
      n.q = a.q;
      n.r = sum;
    end
    return n;
  endfunction

  function automatic logic signed [CW-1:0] place(input logic [CW-1:0] base,
                                                 input logic [QW-1:0] q, input logic neg,
                                                 input logic signed [1:0] j);
    logic signed [CW-1:0] off;
    logic signed [CW-1:0] jw;
    off = $signed(CW'(q));
    if (neg) off = -off;
    jw = {{(CW-2){j[1]}}, j};
    return $signed(base) + off + jw;
  endfunction

  function automatic logic in_view(input logic signed [CW-1:0] c, input logic [CW-1:0] lim);
    return !c[CW-1] && ($unsigned(c) < lim);
  endfunction

  walk_st_t             st_r;
  logic [X_BITS-1:0]    x0_r, e_x0;
  logic [Y_BITS-1:0]    y0_r, e_y0;
  logic [SW-1:0]        adx_r, ady_r, steps_r, e_adx, e_ady, e_steps;
  line_flags_t          flags_r, e_flags;
  logic [HASH_BITS-1:0] h_r, e_hseed;
  logic [IW-1:0]        i_r, i_p1;
  acc_t                 ax_r, ay_r, ax1, ay1, ax2, ay2;

  logic                 out_valid_r;
  logic signed [OUT_X_BITS-1:0] fx_r, sx_r;
  logic signed [OUT_Y_BITS-1:0] fy_r, sy_r;
  logic                 fd_r, sd_r, last_r;

  logic                 out_free, emit, last, sec;
  logic signed [1:0]    jit, jx0, jy0;
  logic signed [CW-1:0] xa, ya, xb, yb;

  assign {e_x0, e_y0, e_adx, e_ady, e_steps, e_flags, e_hseed} = q_data;

  assign q_pop    = (st_r == ST_IDLE) && q_valid;
  assign out_free = !out_valid_r || !out_stall;
  assign emit     = (st_r == ST_WALK) && out_free;

  assign ax1 = dda_step(ax_r, adx_r, steps_r);
  assign ay1 = dda_step(ay_r, ady_r, steps_r);
  assign ax2 = dda_step(ax1, adx_r, steps_r);
  assign ay2 = dda_step(ay1, ady_r, steps_r);

  // Jitter lands on every fourth dot, always the first of a pair.
  assign jit = (i_r[1:0] == 2'b00) ? jitter_of(h_r) : 2'sd0;
  assign jx0 = flags_r.x_major ? 2'sd0 : jit;
  assign jy0 = flags_r.x_major ? jit : 2'sd0;

  assign xa = place(CW'(x0_r), ax_r.q, flags_r.x_neg, jx0);
  assign ya = place(CW'(y0_r), ay_r.q, flags_r.y_neg, jy0);
  assign xb = place(CW'(x0_r), ax1.q, flags_r.x_neg, 2'sd0);
  assign yb = place(CW'(y0_r), ay1.q, flags_r.y_neg, 2'sd0);

  assign i_p1 = i_r + IW'(1);
  assign last = (i_p1 >= IW'(steps_r));
  assign sec  = (i_p1 <= IW'(steps_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_free) out_valid_r <= emit;
      unique case (st_r)
        ST_IDLE: if (q_valid) st_r <= ST_WALK;
        ST_WALK: if (emit && last) st_r <= ST_IDLE;
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x0_r    <= e_x0;
      y0_r    <= e_y0;
      adx_r   <= e_adx;
      ady_r   <= e_ady;
      steps_r <= e_steps;
      flags_r <= e_flags;
      h_r     <= e_hseed;
      i_r     <= '0;
      ax_r    <= '0;
      ay_r    <= '0;
    end else if (emit) begin
      i_r  <= i_r + IW'(2);
      h_r  <= h_r + HASH_STEP2;
      ax_r <= ax2;
      ay_r <= ay2;
    end
    if (emit) begin
      fx_r   <= xa[OUT_X_BITS-1:0];
      fy_r   <= ya[OUT_Y_BITS-1:0];
      fd_r   <= in_view(xa, CW'(view_cfg.width)) && in_view(ya, CW'(view_cfg.height));
      sx_r   <= sec ? xb[OUT_X_BITS-1:0] : '0;
      sy_r   <= sec ? yb[OUT_Y_BITS-1:0] : '0;
      sd_r   <= sec && in_view(xb, CW'(view_cfg.width)) && in_view(yb, CW'(view_cfg.height));
      last_r <= last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_first_dot_x     = fx_r;
  assign out_first_dot_y     = fy_r;
  assign out_first_dot_draw  = fd_r;
  assign out_second_dot_x    = sx_r;
  assign out_second_dot_y    = sy_r;
  assign out_second_dot_draw = sd_r;
  assign out_last_pair       = last_r;

  a_idx_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_WALK) |-> (i_r <= IW'(steps_r)))
    else $error("walker index ran past the line end");

  a_load_walk: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (st_r == ST_WALK) && (i_r == '0))
    else $error("line load did not start a walk at dot zero");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && last) |=> (st_r == ST_IDLE) && out_valid_r && out_last_pair)
    else $error("final pair did not end the walk");

endmodule

FILE: design/jittered_dda_line_rasterizer_unit.sv
// jittered_dda_line_rasterizer_unit: top level; view registers, front, line queue and walker.
// Depends on jdda_pkg, jdda_front, jdda_fifo, jdda_back.
//
//   port group  direction  beat carries
//   in_*        in         one line: start_x, start_y, end_x, end_y
//   out_*       out        one pair of dots: x, y, draw for each, and last_pair
//   cfg_*       in         one register write: index and data, no read-back
//
// A line of n steps yields ceil((n+1)/2) beats, one per clock while the output is not
// stalled, with a load state (ST_IDLE) in the walker between lines; the walker's two chained
// DDA steps per cycle set this rate.
// The front register and the two-entry line queue let new lines enter while a walk runs.
// Reset (synchronous, rst_n low) empties the front and queue, idles the walker and sets the
// view to 128 x 48. Stalls: out_stall holds the output beat; the walker then waits, the queue
// fills and in_stall rises. Zero-length lines are dropped in the front and give no beat.
module jittered_dda_line_rasterizer_unit #(
  parameter int X_BITS = jdda_pkg::X_BITS_DEF,
  parameter int Y_BITS = jdda_pkg::Y_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [X_BITS-1:0]                      in_start_x,
  input  logic [Y_BITS-1:0]                      in_start_y,
  input  logic [X_BITS-1:0]                      in_end_x,
  input  logic [Y_BITS-1:0]                      in_end_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [jdda_pkg::OUT_X_BITS-1:0] out_first_dot_x,
  output logic signed [jdda_pkg::OUT_Y_BITS-1:0] out_first_dot_y,
  output logic                                   out_first_dot_draw,
  output logic signed [jdda_pkg::OUT_X_BITS-1:0] out_second_dot_x,
  output logic signed [jdda_pkg::OUT_Y_BITS-1:0] out_second_dot_y,
  output logic                                   out_second_dot_draw,
  output logic                                   out_last_pair,
  input  logic                                   cfg_we,
  input  logic [jdda_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [jdda_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import jdda_pkg::*;

  localparam int EW = entry_bits(X_BITS, Y_BITS);

  view_cfg_t     view_r;
  logic          push_valid, push_full, pop_valid, pop_ready;
  logic [EW-1:0] push_data, pop_data;

  // View registers; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      view_r.width  <= VIEW_W_RST;
      view_r.height <= VIEW_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_VIEW_WIDTH:  view_r.width  <= cfg_data[VIEW_W_BITS-1:0];
        CFG_VIEW_HEIGHT: view_r.height <= cfg_data[VIEW_H_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Classify the line: deltas, step count, major axis, hash seed.
  jdda_front #(
    .X_BITS (X_BITS),
    .Y_BITS (Y_BITS),
    .EW     (EW)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data)
  );

  // Hold classified lines so front and walker stall independently.
  jdda_fifo #(
    .W (EW)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Walk the line and emit dot pairs through the output register.
  jdda_back #(
    .X_BITS (X_BITS),
    .Y_BITS (Y_BITS),
    .EW     (EW)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .view_cfg            (view_r),
    .q_valid             (pop_valid),
    .q_pop               (pop_ready),
    .q_data              (pop_data),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_first_dot_x     (out_first_dot_x),
    .out_first_dot_y     (out_first_dot_y),
    .out_first_dot_draw  (out_first_dot_draw),
    .out_second_dot_x    (out_second_dot_x),
    .out_second_dot_y    (out_second_dot_y),
    .out_second_dot_draw (out_second_dot_draw),
    .out_last_pair       (out_last_pair)
  );

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps
// tb: self-checking testbench for jittered_dda_line_rasterizer_unit.
// Depends on jdda_pkg and the design files; drives lines and view writes, checks every dot pair.
module tb;
  import jdda_pkg::*;

  localparam int XB = X_BITS_DEF;
  localparam int YB = Y_BITS_DEF;
  localparam int X_MAX = (1 << XB) - 1;
  localparam int Y_MAX = (1 << YB) - 1;
  // Quiet cycles after the last dot pair before the view may change; covers a
  // trailing zero-length line still passing through the front and queue.
  localparam int SETTLE_CYCLES = 10;
  localparam int TAIL_CYCLES = 20;
  // No beat on either channel for this long means the block is hung.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 6;
  localparam int LINES_PER_PHASE = 72;

  // Register indexes past the view pair; the block must ignore writes to them.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE3 = 2'd3;

  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_BURSTY, STALL_HEAVY} stall_mode_t;

  // One out beat: two dots and the end-of-line flag.
  typedef struct packed {
    logic signed [OUT_X_BITS-1:0] first_x;
    logic signed [OUT_Y_BITS-1:0] first_y;
    logic                         first_draw;
    logic signed [OUT_X_BITS-1:0] second_x;
    logic signed [OUT_Y_BITS-1:0] second_y;
    logic                         second_draw;
    logic                         last;
  } dot_pair_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [XB-1:0]                in_start_x = '0;
  logic [YB-1:0]                in_start_y = '0;
  logic [XB-1:0]                in_end_x = '0;
  logic [YB-1:0]                in_end_y = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [OUT_X_BITS-1:0] out_first_dot_x;
  logic signed [OUT_Y_BITS-1:0] out_first_dot_y;
  logic                         out_first_dot_draw;
  logic signed [OUT_X_BITS-1:0] out_second_dot_x;
  logic signed [OUT_Y_BITS-1:0] out_second_dot_y;
  logic                         out_second_dot_draw;
  logic                         out_last_pair;
  logic                         cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_data = '0;

  // Shadow of the view registers, tracked at each write.
  int          view_w = int'(VIEW_W_RST);
  int          view_h = int'(VIEW_H_RST);
  dot_pair_t   pending_pairs[$];
  int          mismatch_cnt = 0;
  int          quiet_cycles = 0;

  // Sender burst shape and receiver stall pattern, retuned by each test.
  int          burst_max = 1;
  int          burst_left = 1;
  int          gap_max = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_hold = 0;

  jittered_dda_line_rasterizer_unit dut (.*);

  always #2 clk = ~clk;

  // Jitter across the dominant axis: multiplicative hash, fold by 16, low two
  // bits minus one, with the top code clamped to +1.
  function automatic int dither_offset(input bit [31:0] r);
    bit [31:0] h;
    int        v;
    h = r * 32'd2654435761;
    h = h ^ (h >> 16);
    v = int'(h[1:0]) - 1;
    if (v > 1) v = 1;
    return v;
  endfunction

  function automatic int lim(input int v, input int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // Walk one line and queue the dot pairs it must produce, in step order.
  task automatic rasterize_line(input int x0, input int y0, input int x1, input int y1);
    int        dx, dy, adx, ady, steps, i, px, py, j;
    bit        x_major, on_view;
    bit [31:0] seed;
    dot_pair_t pair;
    dx = x1 - x0;
    dy = y1 - y0;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    steps = (adx > ady) ? adx : ady;
    // Equal magnitudes count as y-major, so the jitter lands on x.
    x_major = adx > ady;
    seed = 32'(x0 * 7 + y0 * 13);
    pair = '0;
    // A zero-length line gives no beat at all.
    if (steps == 0) return;
    for (i = 0; i <= steps; i++) begin
      px = x0 + (dx * i) / steps;
      py = y0 + (dy * i) / steps;
      if ((i % 4) == 0) begin
        j = dither_offset(32'(i) + seed);
        if (x_major) py += j;
        else px += j;
      end
      on_view = px >= 0 && px < view_w && py >= 0 && py < view_h;
      if ((i % 2) == 0) begin
        pair = '0;
        pair.first_x = px[OUT_X_BITS-1:0];
        pair.first_y = py[OUT_Y_BITS-1:0];
        pair.first_draw = on_view;
      end else begin
        pair.second_x = px[OUT_X_BITS-1:0];
        pair.second_y = py[OUT_Y_BITS-1:0];
        pair.second_draw = on_view;
        pair.last = (i == steps);
        pending_pairs.push_back(pair);
      end
    end
    // Odd dot count: the final beat carries one dot, second slot zeroed.
    if ((steps % 2) == 0) begin
      pair.last = 1'b1;
      pending_pairs.push_back(pair);
    end
  endtask

  // Present one line, hold it until accepted, then predict it. When a burst
  // is used up, drop valid for a random gap before the next line.
  task automatic send_line(input int sx, input int sy, input int ex, input int ey);
    int g;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, burst_max);
      g = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      if (g > 0) begin
        in_valid <= 1'b0;
        repeat (g) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_start_x <= sx[XB-1:0];
    in_start_y <= sy[YB-1:0];
    in_end_x <= ex[XB-1:0];
    in_end_y <= ey[YB-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rasterize_line(sx, sy, ex, ey);
  endtask

  // Hold off the sender until every predicted pair is out and the block is quiet.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (pending_pairs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; only called while the block is idle.
  task automatic write_view_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_VIEW_WIDTH: view_w = int'(value[VIEW_W_BITS-1:0]);
      CFG_VIEW_HEIGHT: view_h = int'(value[VIEW_H_BITS-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Compare each accepted out beat with the oldest predicted pair.
  always @(posedge clk) begin : pair_check
    dot_pair_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pairs.size() == 0) begin
        $error("out beat with no pair pending: first dot (%0d,%0d)",
               out_first_dot_x, out_first_dot_y);
        mismatch_cnt++;
      end else begin
        want = pending_pairs.pop_front();
        check_field("first_dot_x", want.first_x, out_first_dot_x);
        check_field("first_dot_y", want.first_y, out_first_dot_y);
        check_field("first_dot_draw", want.first_draw, out_first_dot_draw);
        check_field("second_dot_x", want.second_x, out_second_dot_x);
        check_field("second_dot_y", want.second_y, out_second_dot_y);
        check_field("second_dot_draw", want.second_draw, out_second_dot_draw);
        check_field("last_pair", want.last, out_last_pair);
      end
    end
  end

  // Receiver stall pattern shaped by mode; bursty and heavy modes hold each level for a random run.
  always @(posedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      case (stall_mode)
        STALL_NONE: out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_BURSTY: begin
          out_stall <= !out_stall;
          stall_hold <= out_stall ? $urandom_range(0, 8) : $urandom_range(0, 5);
        end
        default: begin
          out_stall <= !out_stall;
          stall_hold <= out_stall ? $urandom_range(0, 3) : $urandom_range(2, 12);
        end
      endcase
    end
  end

  // Watchdog: any beat on either channel counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // Line shapes under the reset view (128 x 48): extremes, both majors, equal
  // magnitudes, zero length, short lines with one and two beats.
  task automatic test_line_shapes();
    stall_mode = STALL_LIGHT;
    gap_max = 3;
    burst_max = 4;
    send_line(0, 0, X_MAX, Y_MAX);
    send_line(X_MAX, Y_MAX, 0, 0);
    send_line(0, 0, X_MAX, 0);
    send_line(64, Y_MAX, 64, 0);
    send_line(10, 10, 30, 30);
    send_line(40, 5, 20, 25);
    send_line(7, 7, 7, 7);
    send_line(0, 0, 1, 0);
    send_line(0, 0, 2, 1);
    send_line(X_MAX, 0, 0, Y_MAX);
    send_line(0, Y_MAX, X_MAX, Y_MAX);
    send_line(X_MAX, Y_MAX, X_MAX, Y_MAX);
    send_line(0, 0, 0, 0);
    send_line(0, 5, 3, 40);
  endtask

  // View registers: zero view, widest values, 1 x 1, spare indexes ignored.
  task automatic test_view_registers();
    wait_for_drain();
    write_view_reg(CFG_VIEW_WIDTH, 8'd0);
    write_view_reg(CFG_VIEW_HEIGHT, 8'h80);  // bit 7 is dropped: height 0
    send_line(3, 3, 20, 9);
    wait_for_drain();
    write_view_reg(CFG_VIEW_WIDTH, 8'hFF);
    write_view_reg(CFG_VIEW_HEIGHT, 8'hFF);
    send_line(0, 0, X_MAX, Y_MAX);
    wait_for_drain();
    write_view_reg(CFG_VIEW_WIDTH, 8'd1);
    write_view_reg(CFG_VIEW_HEIGHT, 8'd1);
    send_line(0, 0, 3, 2);
    wait_for_drain();
    write_view_reg(CFG_IDX_SPARE2, 8'h00);
    write_view_reg(CFG_IDX_SPARE3, 8'h00);
    send_line(1, 0, 0, 3);
    wait_for_drain();
    write_view_reg(CFG_VIEW_WIDTH, 8'd128);
    write_view_reg(CFG_VIEW_HEIGHT, 8'd64);
    send_line(X_MAX, Y_MAX, 0, 1);
  endtask

  // Random lines in phases; each phase sets a view and an idling shape. Mostly
  // random spans, plus short, axis, diagonal and near-full lines; zero-length
  // lines are mixed in as noise and not counted.
  task automatic test_random_lines();
    int ph, n, pick, sel, len, sx, sy, ex, ey;
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_for_drain();
      case (ph)
        0: begin
          write_view_reg(CFG_VIEW_WIDTH, 8'd128);
          write_view_reg(CFG_VIEW_HEIGHT, 8'd64);
          stall_mode = STALL_NONE;
          gap_max = 0;
          burst_max = 1;
        end
        1: begin
          write_view_reg(CFG_VIEW_WIDTH, 8'($urandom_range(1, 255)));
          write_view_reg(CFG_VIEW_HEIGHT, 8'($urandom_range(0, 255)));
          stall_mode = STALL_LIGHT;
          gap_max = 2;
          burst_max = 3;
        end
        2: begin
          write_view_reg(CFG_VIEW_WIDTH, 8'hFF);
          write_view_reg(CFG_VIEW_HEIGHT, 8'hFF);
          stall_mode = STALL_HEAVY;
          gap_max = 0;
          burst_max = 8;
        end
        3: begin
          write_view_reg(CFG_VIEW_WIDTH, 8'd0);
          write_view_reg(CFG_VIEW_HEIGHT, 8'($urandom_range(0, 255)));
          stall_mode = STALL_BURSTY;
          gap_max = 25;
          burst_max = 2;
        end
        4: begin
          write_view_reg(CFG_VIEW_WIDTH, 8'd1);
          write_view_reg(CFG_VIEW_HEIGHT, 8'd1);
          stall_mode = STALL_LIGHT;
          gap_max = 6;
          burst_max = 5;
        end
        default: begin
          write_view_reg(CFG_VIEW_WIDTH, 8'($urandom_range(0, 255)));
          write_view_reg(CFG_VIEW_HEIGHT, 8'($urandom_range(0, 255)));
          stall_mode = STALL_BURSTY;
          gap_max = 8;
          burst_max = 6;
        end
      endcase
      n = 0;
      while (n < LINES_PER_PHASE) begin
        pick = $urandom_range(0, 99);
        sx = $urandom_range(0, X_MAX);
        sy = $urandom_range(0, Y_MAX);
        ex = $urandom_range(0, X_MAX);
        ey = $urandom_range(0, Y_MAX);
        if (pick < 5) begin
          send_line(sx, sy, sx, sy);
          continue;
        end
        if (pick >= 55 && pick < 80) begin
          ex = lim(sx + int'($urandom_range(0, 8)) - 4, X_MAX);
          ey = lim(sy + int'($urandom_range(0, 8)) - 4, Y_MAX);
        end else if (pick >= 80 && pick < 90) begin
          len = $urandom_range(1, Y_MAX);
          if ($urandom_range(0, 1) == 1) len = -len;
          sel = $urandom_range(0, 2);
          ex = (sel == 1) ? sx : lim(sx + len, X_MAX);
          ey = (sel == 0) ? sy : lim(sy + len, Y_MAX);
        end else if (pick >= 90) begin
          sx = $urandom_range(0, 7);
          ex = $urandom_range(X_MAX - 7, X_MAX);
          if ($urandom_range(0, 1) == 1) begin
            len = sx;
            sx = ex;
            ex = len;
          end
        end
        send_line(sx, sy, ex, ey);
        n++;
        // Mid-phase in even phases, let the block drain completely before going on.
        if (n == LINES_PER_PHASE / 2 && (ph % 2) == 0) wait_for_drain();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_line_shapes();
    test_view_registers();
    test_random_lines();
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending_pairs.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

FILE: jittered_dda_line_rasterizer_unit.f
design/jdda_pkg.sv
design/jdda_front.sv
design/jdda_fifo.sv
design/jdda_back.sv
design/jittered_dda_line_rasterizer_unit.sv
verif/tb.sv
